// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the byte ring FIFO.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  `ASSERT_CLK(lbl, clk, rst, !(expr))

`endif

// ===== design/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Types and constants shared by the byte ring FIFO modules.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int DATA_W     = 8;
  localparam int FILL_W     = 8;
  localparam int CAP_W      = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = 2'd1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;
  localparam logic [CAP_W-1:0] MIN_SIZE       = 9'd2;

  typedef struct packed {
    logic              ok;
    logic              is_pop;
    logic              is_empty;
    logic              is_full;
    logic [FILL_W-1:0] fill_count;
  } status_t;

endpackage

// ===== design/brf_req_if.sv =====
// ----------------------------------------------------------------------------
// brf_req_if
// Request channel: one push or pop per transfer.
// ----------------------------------------------------------------------------
interface brf_req_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [brf_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink (input valid, input op, input data_in, output ready);
endinterface

// ===== design/brf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// brf_rsp_if
// Response channel: one result per transfer.
// ----------------------------------------------------------------------------
interface brf_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [brf_pkg::DATA_W-1:0] data_out;
  logic                       is_empty;
  logic                       is_full;
  logic [brf_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, output ok, output data_out, output is_empty,
                  output is_full, output fill_count, input ready);
  modport sink (input valid, input ok, input data_out, input is_empty,
                input is_full, input fill_count, output ready);
endinterface

// ===== design/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/brf_ctrl.sv =====
// ----------------------------------------------------------------------------
// brf_ctrl
// Ring pointers, configuration registers, step decision and result status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brf_ctrl #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [brf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                step,
  input  logic                                op,
  input  logic [brf_pkg::DATA_W-1:0]          data_in,
  output logic                                ram_we,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr,
  output logic [brf_pkg::DATA_W-1:0]          ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr,
  output brf_pkg::status_t                    status
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > brf_pkg::CAP_W) ? SW : brf_pkg::CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [brf_pkg::CAP_W-1:0] capacity;
  logic                      overwrite_mode;
  logic [AW-1:0]             write_index;
  logic [AW-1:0]             read_index;

  logic [CW-1:0] cap_ext;
  logic [CW-1:0] size;
  logic          enabled;
  logic          is_push;
  logic          is_pop;
  logic          full_now;
  logic          push_ok;
  logic          pop_ok;
  logic [AW-1:0] wi_adv;
  logic [AW-1:0] ri_adv;
  logic [AW-1:0] write_index_next;
  logic [AW-1:0] read_index_next;
  logic [CW-1:0] wi_ext;
  logic [CW-1:0] ri_ext;
  logic [CW-1:0] fill;
  brf_pkg::status_t status_next;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [CW-1:0] sz);
    logic [CW-1:0] inc;
    inc = CW'(idx) + CW'(1);
    return (inc >= sz) ? AW'(0) : inc[AW-1:0];
  endfunction

  always_comb begin
    cap_ext  = CW'(capacity);
    size     = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    enabled  = size >= CW'(brf_pkg::MIN_SIZE);
    is_push  = op == brf_pkg::OP_PUSH;
    is_pop   = op == brf_pkg::OP_POP;
    wi_adv   = advance(write_index, size);
    ri_adv   = advance(read_index, size);
    full_now = wi_adv == read_index;
    push_ok  = enabled && is_push && (!full_now || overwrite_mode);
    pop_ok   = enabled && is_pop && (write_index != read_index);

    write_index_next = push_ok ? wi_adv : write_index;
    read_index_next  = read_index;
    if ((push_ok && full_now) || pop_ok) begin
      read_index_next = ri_adv;
    end

    wi_ext = CW'(write_index_next);
    ri_ext = CW'(read_index_next);
    if (wi_ext >= ri_ext) begin
      fill = wi_ext - ri_ext;
    end else begin
      fill = size - (ri_ext - wi_ext);
    end

    status_next.ok         = push_ok || pop_ok;
    status_next.is_pop     = is_pop;
    status_next.is_empty   = write_index_next == read_index_next;
    status_next.is_full    = enabled &&
                             (advance(write_index_next, size) == read_index_next);
    status_next.fill_count = enabled ? fill[brf_pkg::FILL_W-1:0] : '0;
  end

  assign ram_we    = step && push_ok;
  assign ram_waddr = write_index;
  assign ram_wdata = data_in;
  assign ram_re    = step && pop_ok;
  assign ram_raddr = read_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= brf_pkg::CAPACITY_RESET;
      overwrite_mode <= 1'b0;
      write_index    <= '0;
      read_index     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        brf_pkg::REG_CAPACITY: begin
          capacity    <= cfg_data[brf_pkg::CAP_W-1:0];
          write_index <= '0;
          read_index  <= '0;
        end
        brf_pkg::REG_OVERWRITE: begin
          overwrite_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (step) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status <= status_next;
    end
  end

  `ASSERT_CLK(a_wi_in_ring, clk, rst, enabled |-> (CW'(write_index) < size))
  `ASSERT_CLK(a_ri_in_ring, clk, rst, enabled |-> (CW'(read_index) < size))
  `ASSERT_NEVER(a_full_and_empty, clk, rst, $past(step) && status.is_full && status.is_empty)

endmodule

// ===== design/byte_ring_fifo.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte ring FIFO keeping one slot empty, with optional overwrite of the oldest
// byte on a push into a full ring.
// ----------------------------------------------------------------------------
// Results: a result appears in the cycle after its request transfer; the slot
// RAM's registered read and the status register set it.
// Throughput: one push or pop per cycle while results are taken; pointers advance at the transfer edge.
// A stalled result holds the request channel until it is taken.
// Reset: synchronous; pointers clear, capacity 256, overwrite off, no result
// pending. Slot contents are not cleared.
module byte_ring_fifo #(
  parameter int DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [brf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brf_pkg::CFG_DATA_W-1:0] cfg_data,
  brf_req_if.sink                        req,
  brf_rsp_if.source                      rsp
);

  localparam int AW = $clog2(DEPTH);

  logic                       step;
  logic                       out_valid;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [brf_pkg::DATA_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [brf_pkg::DATA_W-1:0] ram_rdata;
  brf_pkg::status_t           status;

  assign req.ready = !out_valid || rsp.ready;
  assign step      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  brf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .op        (req.op),
    .data_in   (req.data_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .status    (status)
  );

  brf_ram #(.WIDTH(brf_pkg::DATA_W), .DEPTH(DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rsp.valid      = out_valid;
  assign rsp.ok         = status.ok;
  assign rsp.data_out   = (status.ok && status.is_pop) ? ram_rdata : '0;
  assign rsp.is_empty   = status.is_empty;
  assign rsp.is_full    = status.is_full;
  assign rsp.fill_count = status.fill_count;

  `ASSERT_CLK(a_step_gives_result, clk, rst, step |=> out_valid)
  `ASSERT_CLK(a_read_only_on_step, clk, rst, (ram_re || ram_we) |-> step)
  `ASSERT_NEVER(a_read_during_stall, clk, rst, ram_re && out_valid && !rsp.ready)

endmodule
